// ===== hdl/ivt_pkg.sv =====
package ivt_pkg;

  localparam int unsigned NUM_VECTORS      = 32;
  localparam int unsigned SLOT_W           = $clog2(NUM_VECTORS);
  localparam int unsigned DEF_MAX_HANDLERS = 16;
  localparam int unsigned COUNT_W          = 5;

  localparam logic [SLOT_W-1:0] COMM_SLOT   = SLOT_W'(4);
  localparam logic [31:0]       FLOOR_RESET = 32'h2000_0000;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] slot;
    logic [31:0] new_vector;
  } ivt_in_t;

  typedef struct packed {
    logic [31:0]        answer;
    logic [31:0]        enable_mask;
    logic [31:0]        clear_pending;
    logic [COUNT_W-1:0] handler_count;
  } ivt_out_t;

  // Control from the sequencer to the handler chain.
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } ivt_chain_ctl_t;

  // Status from the handler chain.
  typedef struct packed {
    logic hit;
    logic full;
  } ivt_chain_sts_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ivt_state_t;

endpackage

// ===== hdl/ivt_cell.sv =====
module ivt_cell
  import ivt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  ivt_chain_ctl_t ctl,
  input  logic           remove,
  input  logic [31:0]    addr,
  input  logic           prev_valid,
  input  logic           hit_in,
  input  logic [31:0]    next_entry,
  input  logic           next_valid,
  output logic [31:0]    entry,
  output logic           valid,
  output logic           hit_out
);

  logic [31:0] entry_r, entry_nxt;
  logic        valid_r, valid_nxt;
  logic        match_r, match_nxt;

  // Hit ripples up the row: this cell or one below matched.
  assign hit_out = hit_in | match_r;

  always_comb begin
    match_nxt = match_r;
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.cmp_en) begin
      match_nxt = valid_r && (entry_r == addr);
    end
    if (ctl.upd_en) begin
      if (remove) begin
        // matched cell and all above it take the upper neighbor's word
        if (hit_out) begin
          entry_nxt = next_entry;
          valid_nxt = next_valid;
        end
      end else if (!valid_r && prev_valid) begin
        // first free cell takes the new address
        entry_nxt = addr;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

// ===== hdl/ivt_handler_chain.sv =====
module ivt_handler_chain
  import ivt_pkg::*;
#(
  parameter int unsigned MAX_HANDLERS = DEF_MAX_HANDLERS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ivt_chain_ctl_t ctl,
  input  logic [31:0]    addr,
  output ivt_chain_sts_t sts
);

  logic [31:0] entry [MAX_HANDLERS];
  logic        valid [MAX_HANDLERS];
  logic        hit   [MAX_HANDLERS+1];

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < MAX_HANDLERS; i++) begin : g_cell
    logic        prev_v;
    logic [31:0] next_e;
    logic        next_v;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid[i-1];
    end

    if (i == MAX_HANDLERS - 1) begin : g_last
      assign next_e = '0;
      assign next_v = 1'b0;
    end else begin : g_inner
      assign next_e = entry[i+1];
      assign next_v = valid[i+1];
    end

    ivt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .remove     (hit[MAX_HANDLERS]),
      .addr       (addr),
      .prev_valid (prev_v),
      .hit_in     (hit[i]),
      .next_entry (next_e),
      .next_valid (next_v),
      .entry      (entry[i]),
      .valid      (valid[i]),
      .hit_out    (hit[i+1])
    );
  end

  assign sts.hit  = hit[MAX_HANDLERS];
  assign sts.full = valid[MAX_HANDLERS-1];

endmodule

// ===== hdl/interrupt_vector_table_with_handler_list.sv =====
// Accept registers the request; the EXEC state then loads the result into the output
//   register once it is free. One word at a time: the vector table read and the handler
//   chain compare happen at accept, the update and result load in EXEC.
// A new word is accepted while a finished result still waits in the output register.
// Reset (rst_n low, synchronous): vector table reads as zero, enables and handler
//   list cleared, floor back to 0x2000_0000. No clearing pass; ready the next cycle.
module interrupt_vector_table_with_handler_list
  import ivt_pkg::*;
#(
  parameter int unsigned MAX_HANDLERS = DEF_MAX_HANDLERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ivt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ivt_out_t    out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_HANDLERS + 1);

  // Sequencer and request hold
  ivt_state_t   state_r, state_nxt;
  ivt_in_t      req_r;
  logic         in_fire;
  logic         exec_fire;

  // Vector table: memory with registered read, per-entry written flags
  logic [31:0]  vec_mem [NUM_VECTORS];
  logic [31:0]  rd_r;
  logic [NUM_VECTORS-1:0] vec_vld_r, vec_vld_nxt;

  logic [31:0]  enable_r, enable_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [31:0]  floor_r;

  // Output register
  logic         out_valid_r, out_valid_nxt;
  ivt_out_t     out_data_r, out_result;

  // Handler chain hookup
  ivt_chain_ctl_t chain_ctl;
  ivt_chain_sts_t chain_sts;
  logic [31:0]    chain_addr;

  // Decode of the held request
  logic              slot_ok;
  logic [SLOT_W-1:0] idx;
  logic [31:0]       old_vec;
  logic [31:0]       slot_mask;
  logic              is_set;
  logic              take_handler;
  logic              vec_write;
  logic [31:0]       answer;
  logic [31:0]       clr;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign slot_ok   = (req_r.slot[31:SLOT_W] == '0);
  assign idx       = req_r.slot[SLOT_W-1:0];
  assign old_vec   = vec_vld_r[idx] ? rd_r : 32'd0;
  assign slot_mask = 32'd1 << idx;
  assign is_set    = (req_r.opcode == OP_SET);

  // Slot 4 toggles the comm receive handler list; other slots hit the table.
  assign take_handler = is_set && slot_ok && (idx == COMM_SLOT)
                        && (req_r.new_vector >= floor_r);
  assign vec_write    = is_set && slot_ok && (idx != COMM_SLOT);

  // Chain compares at accept against the incoming address, updates in EXEC.
  assign chain_ctl.cmp_en = in_fire;
  assign chain_ctl.upd_en = exec_fire && take_handler;
  assign chain_addr       = in_fire ? in_data.new_vector : req_r.new_vector;

  ivt_handler_chain #(
    .MAX_HANDLERS (MAX_HANDLERS)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (chain_ctl),
    .addr  (chain_addr),
    .sts   (chain_sts)
  );

  always_comb begin
    answer      = 32'd0;
    clr         = 32'd0;
    enable_nxt  = enable_r;
    total_nxt   = total_r;
    vec_vld_nxt = vec_vld_r;
    if (!is_set) begin
      if (slot_ok) begin
        answer = old_vec;
      end
    end else if (vec_write) begin
      answer = old_vec;
      vec_vld_nxt[idx] = 1'b1;
      if (req_r.new_vector == 32'd0) begin
        enable_nxt = enable_r & ~slot_mask;
      end else begin
        enable_nxt = enable_r | slot_mask;
        clr        = slot_mask;
      end
    end else if (take_handler) begin
      if (chain_sts.hit) begin
        total_nxt = total_r - CW'(1);
      end else if (!chain_sts.full) begin
        answer    = req_r.new_vector;
        total_nxt = total_r + CW'(1);
      end
    end
  end

  always_comb begin
    out_result.answer        = answer;
    out_result.enable_mask   = enable_nxt;
    out_result.clear_pending = clr;
    out_result.handler_count = COUNT_W'(total_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Vector table memory
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r <= vec_mem[in_data.slot[SLOT_W-1:0]];
    end
    if (exec_fire && vec_write) begin
      vec_mem[idx] <= req_r.new_vector;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    if (exec_fire) begin
      out_data_r <= out_result;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vec_vld_r   <= '0;
      enable_r    <= '0;
      total_r     <= '0;
      floor_r     <= FLOOR_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        vec_vld_r <= vec_vld_nxt;
        enable_r  <= enable_nxt;
        total_r   <= total_nxt;
      end
      if (cfg_we) begin
        floor_r <= cfg_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks

  // The handler count tracks the chain occupancy.
  a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    chain_sts.full == (total_r == CW'(MAX_HANDLERS)))
    else $error("handler chain full flag disagrees with handler count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(MAX_HANDLERS))
    else $error("handler count above list capacity");

  // An enabled interrupt always has a written vector.
  a_enable_written: assert property (@(posedge clk) disable iff (!rst_n)
    (enable_r & ~vec_vld_r) == 32'd0)
    else $error("enable bit set for a never-written vector");

  // One word in flight: an accept is followed by a busy cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted while a word is being processed");

endmodule
